// File: design/vcsc_pkg.sv
// Package with the types, codes and constants of the voice capture session controller.
`default_nettype none

package vcsc_pkg;

    // Width of the millisecond timestamps and of the stored times.
    localparam int TIME_W = 32;
    // Width of the configuration registers and of the register index.
    localparam int CFG_W = 32;
    localparam int CFG_INDEX_W = 2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] MAX_CAPTURE_RESET = CFG_W'(8000);
    localparam logic [CFG_W-1:0] SILENCE_LIMIT_RESET = CFG_W'(1500);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_CAPTURE   = 2'd0,
        CFG_SILENCE_LIMIT = 2'd1
    } t_cfg_index;

    // Event codes.
    typedef enum logic [2:0] {
        OP_WAKE_WORD     = 3'd0,
        OP_VOICE         = 3'd1,
        OP_TICK          = 3'd2,
        OP_RESPONSE      = 3'd3,
        OP_PLAYBACK_DONE = 3'd4,
        OP_FAILURE       = 3'd5
    } t_op;

    // Action codes.
    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_BEGIN_STREAM = 3'd1,
        ACT_END_STREAM   = 3'd2,
        ACT_BEGIN_PLAY   = 3'd3,
        ACT_STOP_PLAY    = 3'd4,
        ACT_ABORT_STREAM = 3'd5
    } t_action;

    // Session phases.
    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_AWAIT   = 2'd2,
        PH_PLAY    = 2'd3
    } t_phase;

    // One input item.
    typedef struct packed {
        logic [2:0]        operation;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0] action;
        logic [1:0] phase_now;
        logic       may_stream;
    } t_out_item;

    // Current configuration as seen by the session logic.
    typedef struct packed {
        logic [CFG_W-1:0] max_capture_ms;
        logic [CFG_W-1:0] silence_limit_ms;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/vcsc_cfg_regs.sv
// Configuration registers of the voice capture session controller.
`default_nettype none

module vcsc_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_wr_en,
    input  wire [vcsc_pkg::CFG_INDEX_W-1:0]  i_wr_index,
    input  wire [vcsc_pkg::CFG_W-1:0]        i_wr_data,
    output vcsc_pkg::t_cfg                   o_cfg
);
    import vcsc_pkg::*;

    logic [CFG_W-1:0] r_max_capture_ms;
    logic [CFG_W-1:0] r_silence_limit_ms;

    // Decode the register index; other indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_capture_ms   <= MAX_CAPTURE_RESET;
            r_silence_limit_ms <= SILENCE_LIMIT_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_MAX_CAPTURE:   r_max_capture_ms   <= i_wr_data;
                CFG_SILENCE_LIMIT: r_silence_limit_ms <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.max_capture_ms   = r_max_capture_ms;
    assign o_cfg.silence_limit_ms = r_silence_limit_ms;

endmodule

`default_nettype wire

// File: design/vcsc_session.sv
// Session phase machine with its stored times and the capture timeout checks.
`default_nettype none

module vcsc_session (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  vcsc_pkg::t_in_item  i_item,
    input  vcsc_pkg::t_cfg      i_cfg,
    output vcsc_pkg::t_out_item o_result
);
    import vcsc_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_capture_start, n_capture_start;
    logic [TIME_W-1:0] r_last_activity, n_last_activity;
    t_action           action;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] quiet;
    logic              capture_done;

    // Modular differences wrap with the timestamp counter.
    assign elapsed = i_item.now_ms - r_capture_start;
    assign quiet   = i_item.now_ms - r_last_activity;
    assign capture_done = (elapsed >= i_cfg.max_capture_ms) ||
                          (quiet >= i_cfg.silence_limit_ms);

    // State registers advance only when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_WAIT;
            r_capture_start <= '0;
            r_last_activity <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_capture_start <= n_capture_start;
            r_last_activity <= n_last_activity;
        end
    end

    // Next phase and action for the current event.
    always_comb begin
        n_phase         = r_phase;
        n_capture_start = r_capture_start;
        n_last_activity = r_last_activity;
        action          = ACT_NONE;
        unique case (t_op'(i_item.operation))
            OP_WAKE_WORD: begin
                if (r_phase == PH_WAIT) begin
                    n_capture_start = i_item.now_ms;
                    n_last_activity = i_item.now_ms;
                    n_phase         = PH_CAPTURE;
                    action          = ACT_BEGIN_STREAM;
                end
            end
            OP_VOICE: begin
                if (r_phase == PH_CAPTURE) begin
                    n_last_activity = i_item.now_ms;
                end
            end
            OP_TICK: begin
                if (r_phase == PH_CAPTURE && capture_done) begin
                    n_phase = PH_AWAIT;
                    action  = ACT_END_STREAM;
                end
            end
            OP_RESPONSE: begin
                if (r_phase == PH_AWAIT) begin
                    n_phase = PH_PLAY;
                    action  = ACT_BEGIN_PLAY;
                end
            end
            OP_PLAYBACK_DONE: begin
                if (r_phase == PH_PLAY) begin
                    n_phase = PH_WAIT;
                    action  = ACT_STOP_PLAY;
                end
            end
            OP_FAILURE: begin
                if (r_phase == PH_CAPTURE) begin
                    action = ACT_ABORT_STREAM;
                end else if (r_phase == PH_PLAY) begin
                    action = ACT_STOP_PLAY;
                end
                n_phase = PH_WAIT;
            end
            default: ;
        endcase
    end

    // The result reports the phase after the event.
    assign o_result.action     = action;
    assign o_result.phase_now  = n_phase;
    assign o_result.may_stream = (n_phase == PH_CAPTURE);

endmodule

`default_nettype wire

// File: design/voice_capture_session_controller.sv
// Top level of the voice capture session controller.
//
// Usage: events enter on the input channel (i_in_valid, o_in_stall, i_in_item) and each
// gives exactly one result item on the output channel (o_out_valid, i_out_stall,
// o_out_item). An item is taken at a clock edge where valid is high and stall is low.
// Every accepted item passes an input register, is evaluated against the session
// phase and stored times, and lands in the output register, from which its result
// is offered. One item per cycle is sustained while the receiver does not stall;
// that rate is set by the phase update, whose two timeout subtract-compare paths
// run between the input and output registers.
// When the receiver stalls, the result holds in the output register and the input
// register still takes one more item; stall then reaches the sender.
// Configuration writes (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) are always
// ready and are meant for idle periods; indexes other than 0 and 1 are ignored.
// A synchronous active-low reset empties both registers, sets the phase to waiting,
// clears the stored times and loads the timeout registers with 8000 ms and 1500 ms.
`default_nettype none

module voice_capture_session_controller (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  vcsc_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output vcsc_pkg::t_out_item             o_out_item,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [vcsc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [vcsc_pkg::CFG_W-1:0]       i_cfg_data
);
    import vcsc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    logic      in_accept;
    t_cfg      cfg;
    t_out_item result;

    // The input register moves on whenever the output register is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    vcsc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    vcsc_session u_session (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// File: tb/sv/tb_voice_capture_session_controller.sv
// Self-checking testbench for the voice capture session controller.
`timescale 1ns / 1ps

module tb_voice_capture_session_controller;
    import vcsc_pkg::*;

    // Event codes the block does not define, and register indexes it ignores.
    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int PHASE_COUNT = 8;
    localparam int EVENTS_PER_PHASE = 230;

    // A result pinned by hand for a directed item; when off, the model decides.
    typedef struct packed {
        logic      on;
        t_out_item res;
    } t_pinned;

    typedef struct {
        logic [2:0]        op;
        logic [TIME_W-1:0] t;
        t_pinned           pin;
    } t_step_row;

    localparam t_pinned FREE = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // Pinned result that travels alongside the item on the input channel.
    t_pinned pinned_result = '0;

    // Session model state and its copy of the timeout registers.
    t_phase            sess_phase = PH_WAIT;
    logic [TIME_W-1:0] start_ms = '0;
    logic [TIME_W-1:0] activity_ms = '0;
    logic [CFG_W-1:0]  lim_capture = MAX_CAPTURE_RESET;
    logic [CFG_W-1:0]  lim_silence = SILENCE_LIMIT_RESET;

    // Results still owed by the block, oldest first.
    t_out_item awaited_results[$];

    int unsigned mismatch_count = 0;
    int unsigned sent_count = 0;
    bit          steady = 1'b0;

    // Stimulus clock and the times that boundary ticks aim at.
    logic [TIME_W-1:0] now_t = '0;
    logic [TIME_W-1:0] aim_start = '0;
    logic [TIME_W-1:0] aim_act = '0;

    // Directed items run under the reset timeouts of 8000 ms and 1500 ms.
    t_step_row directed_rows [25] = '{
        // Every event but a wake word does nothing while waiting.
        '{OP_VOICE,         32'd5,          '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        '{OP_TICK,          32'd0,          '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        '{OP_RESPONSE,      32'hFFFF_FFFF,  '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        '{OP_FAILURE,       32'd0,          '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        '{OP_UNDEF_6,       32'd0,          '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        '{OP_UNDEF_7,       32'hFFFF_FFFF,  '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        '{OP_WAKE_WORD,     32'hFFFF_F000,  '{1'b1, '{ACT_BEGIN_STREAM, PH_CAPTURE, 1'b1}}},
        // Capture close to the wrap of the millisecond counter.
        '{OP_WAKE_WORD,     32'd0,          FREE},
        '{OP_TICK,          32'hFFFF_F5DB,  FREE},
        '{OP_VOICE,         32'hFFFF_FA00,  FREE},
        '{OP_TICK,          32'h0000_0100,  FREE},
        '{OP_TICK,          32'h0000_0300,  FREE},
        '{OP_FAILURE,       32'h0000_0400,  '{1'b1, '{ACT_NONE, PH_WAIT, 1'b0}}},
        // Failure in the middle of a capture aborts the stream.
        '{OP_WAKE_WORD,     32'hFFFF_FFFF,  FREE},
        '{OP_FAILURE,       32'd0,          '{1'b1, '{ACT_ABORT_STREAM, PH_WAIT, 1'b0}}},
        // Capture ended by the elapsed limit, exactly on the boundary.
        '{OP_WAKE_WORD,     32'd0,          FREE},
        '{OP_VOICE,         32'd7000,       FREE},
        '{OP_TICK,          32'd7999,       FREE},
        '{OP_TICK,          32'd8000,       FREE},
        '{OP_RESPONSE,      32'd8001,       FREE},
        '{OP_PLAYBACK_DONE, 32'd9000,       FREE},
        // Capture ended by silence exactly on the limit, then failure while playing.
        '{OP_WAKE_WORD,     32'd10000,      FREE},
        '{OP_TICK,          32'd11500,      FREE},
        '{OP_RESPONSE,      32'd11501,      FREE},
        '{OP_FAILURE,       32'd11502,      '{1'b1, '{ACT_STOP_PLAY, PH_WAIT, 1'b0}}}
    };

    voice_capture_session_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Advance the session model by one event and return the result it gives.
    function automatic t_out_item session_step(input t_in_item ev);
        t_out_item         r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] quiet;
        r.action = ACT_NONE;
        case (ev.operation)
            OP_WAKE_WORD: begin
                if (sess_phase == PH_WAIT) begin
                    start_ms = ev.now_ms;
                    activity_ms = ev.now_ms;
                    sess_phase = PH_CAPTURE;
                    r.action = ACT_BEGIN_STREAM;
                end
            end
            OP_VOICE: begin
                if (sess_phase == PH_CAPTURE) begin
                    activity_ms = ev.now_ms;
                end
            end
            OP_TICK: begin
                // Both differences wrap with the millisecond counter.
                elapsed = ev.now_ms - start_ms;
                quiet = ev.now_ms - activity_ms;
                if (sess_phase == PH_CAPTURE &&
                    (elapsed >= lim_capture || quiet >= lim_silence)) begin
                    sess_phase = PH_AWAIT;
                    r.action = ACT_END_STREAM;
                end
            end
            OP_RESPONSE: begin
                if (sess_phase == PH_AWAIT) begin
                    sess_phase = PH_PLAY;
                    r.action = ACT_BEGIN_PLAY;
                end
            end
            OP_PLAYBACK_DONE: begin
                if (sess_phase == PH_PLAY) begin
                    sess_phase = PH_WAIT;
                    r.action = ACT_STOP_PLAY;
                end
            end
            OP_FAILURE: begin
                if (sess_phase == PH_CAPTURE) begin
                    r.action = ACT_ABORT_STREAM;
                end else if (sess_phase == PH_PLAY) begin
                    r.action = ACT_STOP_PLAY;
                end
                sess_phase = PH_WAIT;
            end
            default: begin
            end
        endcase
        r.phase_now = sess_phase;
        r.may_stream = (sess_phase == PH_CAPTURE);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [2:0] want,
                               input logic [2:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
        end
    endtask

    // Predict each accepted item and check each accepted result in order.
    always @(posedge i_clk) begin : scoreboard
        t_out_item predicted;
        t_out_item wanted;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) begin
                predicted = session_step(i_in_item);
                awaited_results.push_back(pinned_result.on ? pinned_result.res : predicted);
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, got action %0d phase %0d",
                             $time, o_out_item.action, o_out_item.phase_now);
                end else begin
                    wanted = awaited_results.pop_front();
                    check_field("action", wanted.action, o_out_item.action);
                    check_field("phase_now", 3'(wanted.phase_now), 3'(o_out_item.phase_now));
                    check_field("may_stream", 3'(wanted.may_stream),
                                3'(o_out_item.may_stream));
                end
            end
        end
    end

    // Receiver: stalls for a random gap before taking each result.
    initial begin : result_sink
        int unsigned hold;
        forever begin
            hold = steady ? 0 : $urandom_range(0, 3);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Offer one event after a random gap and wait until it is taken.
    task automatic send_event(input logic [2:0] op, input logic [TIME_W-1:0] t,
                              input t_pinned pin);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{operation: op, now_ms: t};
        pinned_result <= pin;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_count++;
    endtask

    // Hold off the sender until the block has returned every result.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write one register; the caller lowers the valid after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_MAX_CAPTURE) begin
            lim_capture = val;
        end else if (idx == CFG_SILENCE_LIMIT) begin
            lim_silence = val;
        end
    endtask

    // Move the stimulus clock: mostly small steps, sometimes onto a limit or anywhere.
    task automatic advance_clock();
        int unsigned       pick;
        logic [TIME_W-1:0] span;
        pick = $urandom_range(0, 19);
        span = (lim_silence > 4000) ? 4000 : lim_silence;
        if (pick == 0) begin
            now_t = $urandom();
        end else if (pick == 1) begin
            now_t = aim_start + lim_capture - TIME_W'($urandom_range(0, 1));
        end else if (pick == 2) begin
            now_t = aim_act + lim_silence - TIME_W'($urandom_range(0, 1));
        end else begin
            now_t = now_t + TIME_W'($urandom_range(0, span + span / 2 + 1));
        end
    endtask

    task automatic send_noise();
        send_event(3'($urandom_range(0, 7)), $urandom(), FREE);
    endtask

    // One session: wake word, voice and ticks, then response and playback,
    // with stray events and failures mixed in.
    task automatic play_session();
        int unsigned steps;
        int unsigned pick;
        steady = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 39) == 0) begin
            drain_results();
        end
        if ($urandom_range(0, 3) == 0) begin
            send_noise();
        end
        advance_clock();
        aim_start = now_t;
        aim_act = now_t;
        send_event(OP_WAKE_WORD, now_t, FREE);
        steps = $urandom_range(1, 8);
        repeat (steps) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_event(OP_FAILURE, now_t, FREE);
                return;
            end else if (pick <= 2) begin
                send_noise();
            end else if (pick <= 9) begin
                advance_clock();
                aim_act = now_t;
                send_event(OP_VOICE, now_t, FREE);
            end else begin
                advance_clock();
                send_event(OP_TICK, now_t, FREE);
            end
        end
        // Usually close the capture with a tick right on one of the limits.
        if ($urandom_range(0, 9) < 7) begin
            now_t = $urandom_range(0, 1) ? aim_start + lim_capture : aim_act + lim_silence;
            send_event(OP_TICK, now_t, FREE);
        end
        now_t = now_t + TIME_W'($urandom_range(0, 50));
        send_event(OP_RESPONSE, now_t, FREE);
        if ($urandom_range(0, 4) == 0) begin
            send_noise();
        end
        now_t = now_t + TIME_W'($urandom_range(0, 5000));
        if ($urandom_range(0, 7) == 0) begin
            send_event(OP_FAILURE, now_t, FREE);
        end else begin
            send_event(OP_PLAYBACK_DONE, now_t, FREE);
        end
    endtask

    // Main sequence: reset, directed items, then random sessions under several settings.
    initial begin : stimulus
        logic [CFG_W-1:0] cap;
        logic [CFG_W-1:0] sil;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_event(directed_rows[k].op, directed_rows[k].t, directed_rows[k].pin);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph != 0) begin
                drain_results();
                case (ph)
                    1: begin cap = '0; sil = '0; end
                    2: begin cap = '1; sil = '1; end
                    3: begin cap = 1; sil = '1; end
                    4: begin cap = '1; sil = 1; end
                    7: begin cap = MAX_CAPTURE_RESET; sil = SILENCE_LIMIT_RESET; end
                    default: begin
                        cap = $urandom_range(100, 20000);
                        sil = $urandom_range(50, 5000);
                    end
                endcase
                // Writes to unused indexes must leave both limits alone.
                if (ph == 2 || ph == 5) begin
                    write_reg(CFG_SPARE_A, $urandom());
                end
                write_reg(CFG_MAX_CAPTURE, cap);
                write_reg(CFG_SILENCE_LIMIT, sil);
                if (ph == 2 || ph == 5) begin
                    write_reg(CFG_SPARE_B, $urandom());
                end
                i_cfg_valid <= 1'b0;
            end
            while (sent_count < (ph + 1) * EVENTS_PER_PHASE) begin
                play_session();
            end
        end

        steady = 1'b0;
        drain_results();
        if (mismatch_count == 0) begin
            $display("voice_capture_session_controller verification clean");
        end else begin
            $display("voice_capture_session_controller verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("voice_capture_session_controller verification failed");
        $finish;
    end

endmodule
